>>> rtl/lavm_pkg.sv
// Shared types and constants of the look-at view matrix block.
`default_nettype none
package lavm_pkg;

	localparam int DATA_W     = 32;
	// The largest normalized magnitude lies in [2^29, 2^30).
	localparam int MANT_W     = 30;
	// Root digits of a 62-bit sum of three 60-bit squares.
	localparam int SQRT_STEPS = 31;

	typedef logic [1:0] row_t;

	localparam row_t ROW_SIDE = 2'd0;
	localparam row_t ROW_UP   = 2'd1;
	localparam row_t ROW_FWD  = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] eye_x;
		logic signed [DATA_W-1:0] eye_y;
		logic signed [DATA_W-1:0] eye_z;
		logic signed [DATA_W-1:0] target_x;
		logic signed [DATA_W-1:0] target_y;
		logic signed [DATA_W-1:0] target_z;
		logic signed [DATA_W-1:0] up_x;
		logic signed [DATA_W-1:0] up_y;
		logic signed [DATA_W-1:0] up_z;
	} req_t;

	typedef struct packed {
		row_t                     row_index;
		logic signed [DATA_W-1:0] entry_0;
		logic signed [DATA_W-1:0] entry_1;
		logic signed [DATA_W-1:0] entry_2;
		logic signed [DATA_W-1:0] translation;
		logic                     degenerate;
		logic                     last_row;
	} rsp_t;

endpackage
`default_nettype wire

>>> rtl/lavm_if.sv
// Valid/ready channels for look-at requests and matrix rows.
`default_nettype none
interface lavm_req_if;
	logic          valid;
	logic          ready;
	lavm_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lavm_rsp_if;
	logic          valid;
	logic          ready;
	lavm_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/look_at_view_matrix.sv
// Look-at view matrix: one request of eye, target and up in, three matrix rows out.
//
// Channel req carries eye, target and up hint points in signed Q16.16 (FRAC_BITS
// fraction bits). Channel rsp returns three items per request, rows 0 (side),
// 1 (true up) and 2 (negated forward), each with three entries, the translation
// column, a degenerate flag and a last_row mark on row 2.
// Rows 1 and 2 follow row 0, each shown once the row before it is taken. Each of
// the three normalizers is a chain of FRAC_BITS+38 stages, with one square-root
// digit or one quotient bit per stage in its root and division steps. A new
// request can enter every cycle while the output stage is empty or its last row
// is being taken; sustained throughput is limited by the single row-wide output
// port, which returns three rows per request.
// Reset clears all valid bits and the row counter; the pipe starts empty.
// While a matrix is on display, the whole pipe holds in place and req.ready stays
// low until its last row is taken.
`default_nettype none
module look_at_view_matrix #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lavm_req_if.sink   req,
	lavm_rsp_if.source rsp
);

	localparam int DW     = lavm_pkg::DATA_W;
	localparam int FW     = FRAC_BITS + 2;
	localparam int PW2    = 2 * FW;
	localparam int SRW    = PW2 + 1;
	localparam int DOTW   = 2 * DW + 2;
	localparam int SIDE_C = 3 * DW + 3 * FW + 1;
	localparam logic [DOTW-1:0] HALF    = DOTW'(1) << (FRAC_BITS - 1);
	localparam logic [DOTW-1:0] SAT_NEG = DOTW'(1) << (DW - 1);
	localparam logic [DOTW-1:0] SAT_POS = SAT_NEG - DOTW'(1);

	// round half away from zero, optionally negate, saturate to 32 bits
	function automatic logic signed [DW-1:0] rnd_sat(input logic signed [DOTW-1:0] v,
		input logic negate);
		logic [DOTW-1:0] mag;
		logic [DOTW-1:0] r;
		logic            neg;
		mag = v[DOTW-1] ? DOTW'(-v) : DOTW'(v);
		r   = (mag + HALF) >> FRAC_BITS;
		neg = v[DOTW-1] ^ negate;
		if (!neg && r > SAT_POS) begin
			return $signed(SAT_POS[DW-1:0]);
		end
		if (neg && r > SAT_NEG) begin
			return $signed(SAT_NEG[DW-1:0]);
		end
		return neg ? -$signed(r[DW-1:0]) : $signed(r[DW-1:0]);
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	lavm_pkg::row_t row_q;

	logic signed [DW-1:0] eye_s1 [3];
	logic signed [DW:0]   d_s1   [3];
	logic signed [DW-1:0] up_s1  [3];

	logic signed [FW-1:0] f_n  [3];
	logic signed [FW-1:0] un_n [3];
	logic                 nzf_n, nzu_n, va_n, vb_n;
	logic [2*DW-1:0]      na_side;
	logic [DW-1:0]        nb_side;
	logic signed [DW-1:0] eye_n [3];

	logic signed [PW2-1:0] pr_s2  [6];
	logic signed [FW-1:0]  f_s2   [3];
	logic signed [DW-1:0]  eye_s2 [3];
	logic                  nzf_s2;

	logic signed [SRW-1:0] sr_s3  [3];
	logic signed [FW-1:0]  f_s3   [3];
	logic signed [DW-1:0]  eye_s3 [3];
	logic                  nzf_s3;

	logic signed [FW-1:0] s_n [3];
	logic                 nzs_n, vc_n;
	logic [SIDE_C-1:0]    nc_side;
	logic signed [DW-1:0] eye_c [3];
	logic signed [FW-1:0] f_c   [3];
	logic                 nzf_c;

	logic signed [PW2-1:0] pr_s4  [6];
	logic signed [FW-1:0]  s_s4   [3];
	logic signed [FW-1:0]  f_s4   [3];
	logic signed [DW-1:0]  eye_s4 [3];
	logic                  degen_s4;

	logic signed [SRW-1:0] tr_s5  [3];
	logic signed [FW-1:0]  s_s5   [3];
	logic signed [FW-1:0]  f_s5   [3];
	logic signed [DW-1:0]  eye_s5 [3];
	logic                  degen_s5;

	logic signed [DW-1:0] t_s6   [3];
	logic signed [FW-1:0] s_s6   [3];
	logic signed [FW-1:0] f_s6   [3];
	logic signed [DW-1:0] eye_s6 [3];
	logic                 degen_s6;

	logic signed [DW-1:0]   row_d   [3][3];
	logic signed [DW-1:0]   row_s7  [3][3];
	logic signed [2*DW-1:0] prd_s7  [3][3];
	logic                   degen_s7;

	logic signed [DW-1:0]   row_s8  [3][3];
	logic signed [DOTW-1:0] dot_s8  [3];
	logic                   degen_s8;

	logic signed [DW-1:0] row_s9   [3][3];
	logic signed [DW-1:0] trans_s9 [3];
	logic                 degen_s9;

	// the last stage doubles as the output register
	assign en        = !v_s9 || (rsp.ready && row_q == lavm_pkg::ROW_FWD);
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= va_n & vb_n;
			v_s3 <= v_s2;
			v_s4 <= vc_n;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// step through rows 0..2 of the item on display
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= lavm_pkg::ROW_SIDE;
		end else if (v_s9 && rsp.ready) begin
			if (row_q == lavm_pkg::ROW_FWD) begin
				row_q <= lavm_pkg::ROW_SIDE;
			end else begin
				row_q <= row_q + lavm_pkg::row_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eye_s1[0] <= req.data.eye_x;
			eye_s1[1] <= req.data.eye_y;
			eye_s1[2] <= req.data.eye_z;
			d_s1[0]   <= (DW+1)'(req.data.target_x) - (DW+1)'(req.data.eye_x);
			d_s1[1]   <= (DW+1)'(req.data.target_y) - (DW+1)'(req.data.eye_y);
			d_s1[2]   <= (DW+1)'(req.data.target_z) - (DW+1)'(req.data.eye_z);
			up_s1[0]  <= req.data.up_x;
			up_s1[1]  <= req.data.up_y;
			up_s1[2]  <= req.data.up_z;
		end
	end

	lavm_norm #(.IN_W(DW + 1), .FRAC_BITS(FRAC_BITS), .SIDE_W(2 * DW)) u_norm_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.vin      (d_s1),
		.side_in  ({eye_s1[0], eye_s1[1]}),
		.out_valid(va_n),
		.vout     (f_n),
		.nz       (nzf_n),
		.side_out (na_side)
	);

	lavm_norm #(.IN_W(DW), .FRAC_BITS(FRAC_BITS), .SIDE_W(DW)) u_norm_up (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.vin      (up_s1),
		.side_in  (eye_s1[2]),
		.out_valid(vb_n),
		.vout     (un_n),
		.nz       (nzu_n),
		.side_out (nb_side)
	);

	assign eye_n[0] = na_side[2*DW-1:DW];
	assign eye_n[1] = na_side[DW-1:0];
	assign eye_n[2] = nb_side;

	// raw side vector: cross(forward, up)
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s2[0] <= PW2'(f_n[1]) * PW2'(un_n[2]);
			pr_s2[1] <= PW2'(f_n[2]) * PW2'(un_n[1]);
			pr_s2[2] <= PW2'(f_n[2]) * PW2'(un_n[0]);
			pr_s2[3] <= PW2'(f_n[0]) * PW2'(un_n[2]);
			pr_s2[4] <= PW2'(f_n[0]) * PW2'(un_n[1]);
			pr_s2[5] <= PW2'(f_n[1]) * PW2'(un_n[0]);
			f_s2     <= f_n;
			eye_s2   <= eye_n;
			// a zero up hint also zeroes the side vector
			nzf_s2   <= nzf_n && nzu_n;
			for (int i = 0; i < 3; i++) begin
				sr_s3[i] <= SRW'(pr_s2[2*i]) - SRW'(pr_s2[2*i+1]);
			end
			f_s3   <= f_s2;
			eye_s3 <= eye_s2;
			nzf_s3 <= nzf_s2;
		end
	end

	lavm_norm #(.IN_W(SRW), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_C)) u_norm_side (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.vin      (sr_s3),
		.side_in  ({eye_s3[0], eye_s3[1], eye_s3[2], f_s3[0], f_s3[1], f_s3[2], nzf_s3}),
		.out_valid(vc_n),
		.vout     (s_n),
		.nz       (nzs_n),
		.side_out (nc_side)
	);

	assign eye_c[0] = nc_side[SIDE_C-1 -: DW];
	assign eye_c[1] = nc_side[SIDE_C-1-DW -: DW];
	assign eye_c[2] = nc_side[SIDE_C-1-2*DW -: DW];
	assign f_c[0]   = nc_side[3*FW:2*FW+1];
	assign f_c[1]   = nc_side[2*FW:FW+1];
	assign f_c[2]   = nc_side[FW:1];
	assign nzf_c    = nc_side[0];

	// true up: cross(side, forward), then round to FRAC_BITS
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s4[0] <= PW2'(s_n[1]) * PW2'(f_c[2]);
			pr_s4[1] <= PW2'(s_n[2]) * PW2'(f_c[1]);
			pr_s4[2] <= PW2'(s_n[2]) * PW2'(f_c[0]);
			pr_s4[3] <= PW2'(s_n[0]) * PW2'(f_c[2]);
			pr_s4[4] <= PW2'(s_n[0]) * PW2'(f_c[1]);
			pr_s4[5] <= PW2'(s_n[1]) * PW2'(f_c[0]);
			s_s4     <= s_n;
			f_s4     <= f_c;
			eye_s4   <= eye_c;
			degen_s4 <= !(nzf_c && nzs_n);
			for (int i = 0; i < 3; i++) begin
				tr_s5[i] <= SRW'(pr_s4[2*i]) - SRW'(pr_s4[2*i+1]);
				t_s6[i]  <= rnd_sat(DOTW'(tr_s5[i]), 1'b0);
			end
			s_s5     <= s_s4;
			f_s5     <= f_s4;
			eye_s5   <= eye_s4;
			degen_s5 <= degen_s4;
			s_s6     <= s_s5;
			f_s6     <= f_s5;
			eye_s6   <= eye_s5;
			degen_s6 <= degen_s5;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_d[lavm_pkg::ROW_SIDE][i] = DW'(s_s6[i]);
			row_d[lavm_pkg::ROW_UP][i]   = t_s6[i];
			row_d[lavm_pkg::ROW_FWD][i]  = -DW'(f_s6[i]);
		end
	end

	// translation column: minus dot(row, eye)
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prd_s7[r][c] <= (2*DW)'(row_d[r][c]) * (2*DW)'(eye_s6[c]);
				end
				dot_s8[r]   <= DOTW'(prd_s7[r][0]) + DOTW'(prd_s7[r][1])
					+ DOTW'(prd_s7[r][2]);
				trans_s9[r] <= rnd_sat(dot_s8[r], 1'b1);
			end
			row_s7   <= row_d;
			degen_s7 <= degen_s6;
			row_s8   <= row_s7;
			degen_s8 <= degen_s7;
			row_s9   <= row_s8;
			degen_s9 <= degen_s8;
		end
	end

	assign rsp.valid            = v_s9;
	assign rsp.data.row_index   = row_q;
	assign rsp.data.entry_0     = row_s9[row_q][0];
	assign rsp.data.entry_1     = row_s9[row_q][1];
	assign rsp.data.entry_2     = row_s9[row_q][2];
	assign rsp.data.translation = trans_s9[row_q];
	assign rsp.data.degenerate  = degen_s9;
	assign rsp.data.last_row    = row_q == lavm_pkg::ROW_FWD;

endmodule
`default_nettype wire

>>> rtl/lavm_norm.sv
// Pipelined 3-vector normalizer: scale, sum of squares, square root, division.
`default_nettype none
module lavm_norm #(
	parameter int IN_W      = 33,
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 1
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic signed [IN_W-1:0]   vin [3],
	input  wire logic [SIDE_W-1:0]        side_in,
	output logic                          out_valid,
	output logic signed [FRAC_BITS+1:0]   vout [3],
	output logic                          nz,
	output logic [SIDE_W-1:0]             side_out
);

	localparam int MW      = lavm_pkg::MANT_W;
	localparam int SQ      = lavm_pkg::SQRT_STEPS;
	localparam int PW      = $clog2(IN_W);
	localparam int RW      = SQ;
	localparam int RMW     = SQ + 2;
	localparam int NSW     = 2 * SQ;
	localparam int NW      = RW + FRAC_BITS;
	localparam int QW      = FRAC_BITS + 1;
	localparam int ST_SUM  = 4;
	localparam int ST_PREP = ST_SUM + SQ + 1;
	localparam int ST_DL   = ST_PREP + FRAC_BITS + 1;
	localparam int ST      = ST_DL + 1;

	logic              vld_s  [1:ST];
	logic [SIDE_W-1:0] side_s [1:ST];

	logic [IN_W-1:0] mag_d [3];
	logic [IN_W-1:0] or_d;
	logic [PW-1:0]   top_d;
	logic [IN_W-1:0] mag_s1 [3];
	logic [2:0]      neg_s1;
	logic [PW-1:0]   top_s1;
	logic            nz_s1;

	logic [MW-1:0]   m_d [3];
	logic [2:0]      neg_s [2:ST-1];
	logic            nz_s  [2:ST-1];
	logic [MW-1:0]   m_s   [2:ST_PREP-1][3];
	logic [2*MW-1:0] sq_s3 [3];

	logic [NSW-1:0] rt_n_s   [ST_SUM:ST_PREP-2];
	logic [RMW-1:0] rt_rem_s [ST_SUM:ST_PREP-2];
	logic [RW-1:0]  rt_s     [ST_SUM:ST_PREP-1];

	logic [NW-1:0] dv_rem_s [ST_PREP:ST_DL-1][3];
	logic [QW-1:0] dv_q_s   [ST_PREP:ST_DL][3];
	logic [RW-1:0] dv_len_s [ST_PREP:ST_DL-1];

	// magnitudes and position of the highest set bit among them
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_d[i] = vin[i][IN_W-1] ? IN_W'(-vin[i]) : IN_W'(vin[i]);
		end
		or_d  = mag_d[0] | mag_d[1] | mag_d[2];
		top_d = '0;
		for (int b = 0; b < IN_W; b++) begin
			if (or_d[b]) begin
				top_d = PW'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= side_in;
			mag_s1    <= mag_d;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vin[i][IN_W-1];
			end
			top_s1 <= top_d;
			nz_s1  <= |or_d;
		end
	end

	// bring the largest magnitude into [2^29, 2^30)
	always_comb begin
		logic [IN_W+MW-1:0] ext;
		for (int i = 0; i < 3; i++) begin
			ext = {{MW{1'b0}}, mag_s1[i]};
			if (top_s1 >= PW'(MW - 1)) begin
				ext = ext >> (top_s1 - PW'(MW - 1));
			end else begin
				ext = ext << (PW'(MW - 1) - top_s1);
			end
			m_d[i] = ext[MW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[2]   <= m_d;
			neg_s[2] <= neg_s1;
			nz_s[2]  <= nz_s1;
		end
	end

	for (genvar g = 2; g <= ST; g++) begin : g_chain
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_s[g-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g] <= side_s[g-1];
			end
		end
	end

	for (genvar g = 3; g <= ST - 1; g++) begin : g_flags
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[g] <= neg_s[g-1];
				nz_s[g]  <= nz_s[g-1];
			end
		end
	end

	for (genvar g = 3; g <= ST_PREP - 1; g++) begin : g_mant
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[g] <= m_s[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= (2*MW)'(m_s[2][i]) * (2*MW)'(m_s[2][i]);
			end
			rt_n_s[ST_SUM]   <= NSW'(sq_s3[0]) + NSW'(sq_s3[1]) + NSW'(sq_s3[2]);
			rt_rem_s[ST_SUM] <= '0;
			rt_s[ST_SUM]     <= '0;
		end
	end

	// one root digit per stage
	for (genvar g = ST_SUM + 1; g <= ST_PREP - 1; g++) begin : g_sqrt
		logic [RMW-1:0] rem_t;
		logic [RMW-1:0] trial;
		logic           take;
		assign rem_t = {rt_rem_s[g-1][RMW-3:0], rt_n_s[g-1][NSW-1 -: 2]};
		assign trial = (RMW'(rt_s[g-1]) << 2) | RMW'(1);
		assign take  = rem_t >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[g] <= {rt_s[g-1][RW-2:0], take};
			end
		end
		if (g < ST_PREP - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rt_rem_s[g] <= take ? rem_t - trial : rem_t;
					rt_n_s[g]   <= rt_n_s[g-1] << 2;
				end
			end
		end
	end

	// numerators with half the length added for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			dv_len_s[ST_PREP] <= rt_s[ST_PREP-1];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[ST_PREP][i] <= (NW'(m_s[ST_PREP-1][i]) << FRAC_BITS)
					+ NW'(rt_s[ST_PREP-1] >> 1);
				dv_q_s[ST_PREP][i]   <= '0;
			end
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar g = ST_PREP + 1; g <= ST_DL; g++) begin : g_div
		localparam int B = ST_DL - g;
		logic [NW-1:0] trial;
		logic [NW-1:0] rem_n [3];
		logic [QW-1:0] q_n   [3];
		assign trial = NW'(dv_len_s[g-1]) << B;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem_n[i] = dv_rem_s[g-1][i];
				q_n[i]   = dv_q_s[g-1][i];
				if (dv_rem_s[g-1][i] >= trial) begin
					rem_n[i] = dv_rem_s[g-1][i] - trial;
					q_n[i][B] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_q_s[g] <= q_n;
			end
		end
		if (g < ST_DL) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[g] <= rem_n;
					dv_len_s[g] <= dv_len_s[g-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (!nz_s[ST-1]) begin
					vout[i] <= '0;
				end else if (neg_s[ST-1][i]) begin
					vout[i] <= -$signed({1'b0, dv_q_s[ST_DL][i]});
				end else begin
					vout[i] <= $signed({1'b0, dv_q_s[ST_DL][i]});
				end
			end
			nz <= nz_s[ST-1];
		end
	end

	assign out_valid = vld_s[ST];
	assign side_out  = side_s[ST];

endmodule
`default_nettype wire
